[design/pidaw_pkg.sv]
// ----------------------------------------------------------------------------
// pidaw_pkg
// Types, constants and arithmetic helpers for the angle-wrapping PID core.
// ----------------------------------------------------------------------------
package pidaw_pkg;

    // Deadband center in whole units; its Q16.16 value may exceed 32 bits
    localparam int DEADBAND_CENTER = 0;
    localparam logic signed [33:0] BAND_CENTER_Q = 34'(longint'(DEADBAND_CENTER) * 65536);

    // One turn (360.0) and half a turn in Q16.16
    localparam logic signed [33:0] TURN_Q      = 34'(360 * 65536);
    localparam logic signed [33:0] HALF_TURN_Q = 34'(180 * 65536);

    localparam logic signed [63:0] S32_MAX = 64'sd2147483647;
    localparam logic signed [63:0] S32_MIN = -64'sd2147483648;

    // Configuration register indexes
    typedef enum logic [2:0] {
        REG_GAIN_P    = 3'd0,
        REG_GAIN_I    = 3'd1,
        REG_GAIN_D    = 3'd2,
        REG_DRIVE_MIN = 3'd3,
        REG_DRIVE_MAX = 3'd4,
        REG_BAND_LOW  = 3'd5,
        REG_BAND_HIGH = 3'd6,
        REG_OPTIONS   = 3'd7
    } reg_index_t;

    // Word operation codes
    localparam logic OP_COMPUTE = 1'b0;
    localparam logic OP_CLEAR   = 1'b1;

    // Option bits
    localparam int OPT_P_ON_ERROR = 0;
    localparam int OPT_ANGLE      = 1;
    localparam int OPT_CLAMP      = 2;

    typedef struct packed {
        logic               operation;
        logic signed [31:0] measurement;
        logic signed [31:0] target;
    } in_word_t;

    typedef struct packed {
        logic signed [31:0] drive;
        logic signed [31:0] integral_term;
        logic signed [31:0] derivative_term;
    } out_word_t;

    // Saturate to the signed 32-bit range
    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > S32_MAX)
            r = 32'sh7FFF_FFFF;
        else if (v < S32_MIN)
            r = 32'sh8000_0000;
        else
            r = v[31:0];
        return r;
    endfunction

    // Clamp to [lo, hi]; with crossed limits, values above hi give hi, all others lo
    function automatic logic signed [31:0] clamp_lim(input logic signed [31:0] v,
                                                     input logic signed [31:0] lo,
                                                     input logic signed [31:0] hi);
        logic signed [31:0] r;
        if (v > hi)
            r = hi;
        else if (v < lo)
            r = lo;
        else
            r = v;
        return r;
    endfunction

endpackage

[design/pid_controller_angle_wrap_core.sv]
// ----------------------------------------------------------------------------
// pid_controller_angle_wrap_core
// PID step on Q16.16 samples with optional angle wrap, clamps and deadband.
// ----------------------------------------------------------------------------
// One word per clock is accepted when not stalled; one result word is returned
// per input word, five pipeline registers later (input, difference, product,
// integral, result). The rate of one word per cycle is set by the integral
// loop, which closes within the single integral stage: add, saturate, subtract
// and clamp. The three gain multiplies run in parallel in the product stage. A
// clear word zeroes the integral and the previous measurement and returns all
// zeros. Configuration writes take effect at once and must be made while idle.
module pid_controller_angle_wrap_core
(
    input  logic                 clk,
    input  logic                 rst_n,

    input  logic                 cfg_write,
    input  logic [2:0]           cfg_index,
    input  logic [31:0]          cfg_data,

    input  logic                 in_valid,
    output logic                 in_ready,
    input  pidaw_pkg::in_word_t  in_data,

    output logic                 out_valid,
    input  logic                 out_ready,
    output pidaw_pkg::out_word_t out_data
);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic signed [31:0] gain_p_reg, gain_i_reg, gain_d_reg;
    logic signed [31:0] drive_min_reg, drive_max_reg;
    logic signed [31:0] band_low_reg, band_high_reg;
    logic [2:0]         options_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_p_reg    <= '0;
            gain_i_reg    <= '0;
            gain_d_reg    <= '0;
            drive_min_reg <= 32'sh8000_0000;
            drive_max_reg <= 32'sh7FFF_FFFF;
            band_low_reg  <= '0;
            band_high_reg <= '0;
            options_reg   <= 3'd1;
        end
        else if (cfg_write)
        begin
            unique case (pidaw_pkg::reg_index_t'(cfg_index))
                pidaw_pkg::REG_GAIN_P:    gain_p_reg    <= cfg_data;
                pidaw_pkg::REG_GAIN_I:    gain_i_reg    <= cfg_data;
                pidaw_pkg::REG_GAIN_D:    gain_d_reg    <= cfg_data;
                pidaw_pkg::REG_DRIVE_MIN: drive_min_reg <= cfg_data;
                pidaw_pkg::REG_DRIVE_MAX: drive_max_reg <= cfg_data;
                pidaw_pkg::REG_BAND_LOW:  band_low_reg  <= cfg_data;
                pidaw_pkg::REG_BAND_HIGH: band_high_reg <= cfg_data;
                pidaw_pkg::REG_OPTIONS:   options_reg   <= cfg_data[2:0];
                default: ;
            endcase
        end
    end

    logic p_on_err, angle_mode, clamp_on;
    assign p_on_err   = options_reg[pidaw_pkg::OPT_P_ON_ERROR];
    assign angle_mode = options_reg[pidaw_pkg::OPT_ANGLE];
    assign clamp_on   = options_reg[pidaw_pkg::OPT_CLAMP];

    // ------------------------------------------------------------------
    // Pipeline flow control: a stage loads when empty or draining
    // ------------------------------------------------------------------
    logic s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg, out_valid_reg;
    logic s1_ready, s2_ready, s3_ready, s4_ready, out_load_ok;

    assign out_load_ok = !out_valid_reg || out_ready;
    assign s4_ready    = !s4_valid_reg || out_load_ok;
    assign s3_ready    = !s3_valid_reg || s4_ready;
    assign s2_ready    = !s2_valid_reg || s3_ready;
    assign s1_ready    = !s1_valid_reg || s2_ready;
    assign in_ready    = s1_ready;
    assign out_valid   = out_valid_reg;

    logic s1_move, s2_move, s3_move, s4_move;
    assign s1_move = s1_valid_reg && s2_ready;
    assign s2_move = s2_valid_reg && s3_ready;
    assign s3_move = s3_valid_reg && s4_ready;
    assign s4_move = s4_valid_reg && out_load_ok;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            s4_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_ready)    s1_valid_reg  <= in_valid;
            if (s2_ready)    s2_valid_reg  <= s1_valid_reg;
            if (s3_ready)    s3_valid_reg  <= s2_valid_reg;
            if (s4_ready)    s4_valid_reg  <= s3_valid_reg;
            if (out_load_ok) out_valid_reg <= s4_valid_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: input register
    // ------------------------------------------------------------------
    pidaw_pkg::in_word_t s1_word_reg;

    always_ff @(posedge clk)
    begin
        if (s1_ready && in_valid)
            s1_word_reg <= in_data;
    end

    // ------------------------------------------------------------------
    // Error and change, angle wrap, saturation
    // ------------------------------------------------------------------
    logic signed [31:0] prev_meas_reg;
    logic signed [31:0] prev_meas_next;
    logic signed [33:0] err_raw, chg_raw, err_wrap, chg_wrap;
    logic signed [31:0] err_sat, chg_sat;

    always_comb
    begin
        err_raw = 34'(s1_word_reg.target) - 34'(s1_word_reg.measurement);
        chg_raw = 34'(s1_word_reg.measurement) - 34'(prev_meas_reg);
        err_wrap = err_raw;
        chg_wrap = chg_raw;
        if (angle_mode)
        begin
            // error: above half a turn drops a turn, at or below minus half adds one
            if (err_raw > pidaw_pkg::HALF_TURN_Q)
                err_wrap = err_raw - pidaw_pkg::TURN_Q;
            else if (err_raw <= -pidaw_pkg::HALF_TURN_Q)
                err_wrap = err_raw + pidaw_pkg::TURN_Q;
            // change: mirrored tie-breaking
            if (chg_raw < -pidaw_pkg::HALF_TURN_Q)
                chg_wrap = chg_raw + pidaw_pkg::TURN_Q;
            else if (chg_raw >= pidaw_pkg::HALF_TURN_Q)
                chg_wrap = chg_raw - pidaw_pkg::TURN_Q;
        end
        err_sat = pidaw_pkg::sat32(64'(err_wrap));
        chg_sat = pidaw_pkg::sat32(64'(chg_wrap));

        prev_meas_next = prev_meas_reg;
        if (s1_move)
        begin
            if (s1_word_reg.operation == pidaw_pkg::OP_CLEAR)
                prev_meas_next = '0;
            else
                prev_meas_next = s1_word_reg.measurement;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            prev_meas_reg <= '0;
        else
            prev_meas_reg <= prev_meas_next;
    end

    // ------------------------------------------------------------------
    // Stage 2: difference register
    // ------------------------------------------------------------------
    logic               s2_op_reg;
    logic signed [31:0] s2_err_reg, s2_chg_reg;

    always_ff @(posedge clk)
    begin
        if (s1_move)
        begin
            s2_op_reg  <= s1_word_reg.operation;
            s2_err_reg <= err_sat;
            s2_chg_reg <= chg_sat;
        end
    end

    // ------------------------------------------------------------------
    // Gain multiplies, floor of product / 2^16
    // ------------------------------------------------------------------
    logic signed [31:0] p_operand;
    logic signed [63:0] prod_i, prod_p, prod_d;

    assign p_operand = p_on_err ? s2_err_reg : s2_chg_reg;
    assign prod_i    = gain_i_reg * s2_err_reg;
    assign prod_p    = gain_p_reg * p_operand;
    assign prod_d    = gain_d_reg * s2_chg_reg;

    // ------------------------------------------------------------------
    // Stage 3: product register
    // ------------------------------------------------------------------
    logic               s3_op_reg;
    logic signed [47:0] s3_qi_reg, s3_qp_reg, s3_qd_reg;

    always_ff @(posedge clk)
    begin
        if (s2_move)
        begin
            s3_op_reg <= s2_op_reg;
            s3_qi_reg <= prod_i[63:16];
            s3_qp_reg <= prod_p[63:16];
            s3_qd_reg <= prod_d[63:16];
        end
    end

    // ------------------------------------------------------------------
    // Integral update
    // ------------------------------------------------------------------
    logic signed [31:0] integral_sum_reg, integral_sum_next;
    logic signed [31:0] iterm_val, sum_sub, sum_val;

    always_comb
    begin
        iterm_val = pidaw_pkg::sat32(64'(integral_sum_reg) + 64'(s3_qi_reg));
        if (p_on_err)
            sum_sub = iterm_val;
        else
            sum_sub = pidaw_pkg::sat32(64'(iterm_val) - 64'(s3_qp_reg));
        if (clamp_on)
            sum_val = pidaw_pkg::clamp_lim(sum_sub, drive_min_reg, drive_max_reg);
        else
            sum_val = sum_sub;

        integral_sum_next = integral_sum_reg;
        if (s3_move)
        begin
            if (s3_op_reg == pidaw_pkg::OP_CLEAR)
                integral_sum_next = '0;
            else
                integral_sum_next = sum_val;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            integral_sum_reg <= '0;
        else
            integral_sum_reg <= integral_sum_next;
    end

    // ------------------------------------------------------------------
    // Stage 4: integral register
    // ------------------------------------------------------------------
    logic               s4_op_reg;
    logic signed [31:0] s4_sum_reg, s4_iterm_reg;
    logic signed [47:0] s4_qp_reg, s4_qd_reg;

    always_ff @(posedge clk)
    begin
        if (s3_move)
        begin
            s4_op_reg    <= s3_op_reg;
            s4_sum_reg   <= sum_val;
            s4_iterm_reg <= iterm_val;
            s4_qp_reg    <= s3_qp_reg;
            s4_qd_reg    <= s3_qd_reg;
        end
    end

    // ------------------------------------------------------------------
    // Drive sum, clamp and deadband
    // ------------------------------------------------------------------
    logic signed [63:0] p_term, drive_raw;
    logic signed [31:0] drive_sat, drive_lim, drive_val;
    logic signed [33:0] drive_ext;
    logic               band_on;
    pidaw_pkg::out_word_t out_word_next;

    always_comb
    begin
        p_term    = p_on_err ? 64'(s4_qp_reg) : 64'sd0;
        drive_raw = p_term + 64'(s4_sum_reg) - 64'(s4_qd_reg);
        drive_sat = pidaw_pkg::sat32(drive_raw);
        if (clamp_on)
            drive_lim = pidaw_pkg::clamp_lim(drive_sat, drive_min_reg, drive_max_reg);
        else
            drive_lim = drive_sat;

        band_on = (34'(band_low_reg) < pidaw_pkg::BAND_CENTER_Q)
               && (pidaw_pkg::BAND_CENTER_Q < 34'(band_high_reg));
        drive_ext = 34'(drive_lim);
        drive_val = drive_lim;
        if (band_on)
        begin
            if (drive_ext > pidaw_pkg::BAND_CENTER_Q && drive_ext < 34'(band_high_reg))
                drive_val = band_high_reg;
            else if (drive_ext < pidaw_pkg::BAND_CENTER_Q && drive_ext > 34'(band_low_reg))
                drive_val = band_low_reg;
        end

        if (s4_op_reg == pidaw_pkg::OP_CLEAR)
        begin
            out_word_next = '0;
        end
        else
        begin
            out_word_next.drive           = drive_val;
            out_word_next.integral_term   = s4_iterm_reg;
            out_word_next.derivative_term = pidaw_pkg::sat32(64'(s4_qd_reg));
        end
    end

    // ------------------------------------------------------------------
    // Result register
    // ------------------------------------------------------------------
    pidaw_pkg::out_word_t out_word_reg;

    always_ff @(posedge clk)
    begin
        if (s4_move)
            out_word_reg <= out_word_next;
    end

    assign out_data = out_word_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_clear_zeroes_integral: assert property (@(posedge clk) disable iff (!rst_n)
        (s3_move && s3_op_reg == pidaw_pkg::OP_CLEAR) |=> (integral_sum_reg == '0))
        else $error("integral not cleared by clear word");

    a_integral_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !s3_move |=> $stable(integral_sum_reg))
        else $error("integral changed without a word passing");

    a_prev_meas_tracks: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_move && s1_word_reg.operation == pidaw_pkg::OP_COMPUTE)
            |=> (prev_meas_reg == $past(s1_word_reg.measurement)))
        else $error("previous measurement not updated");

    a_clear_result_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (s4_move && s4_op_reg == pidaw_pkg::OP_CLEAR) |=> (out_valid && out_data == '0))
        else $error("clear word gave a nonzero result");

endmodule

[dv/pid_controller_angle_wrap_core_tb.sv]
// ----------------------------------------------------------------------------
// pid_controller_angle_wrap_core_tb
// Self-checking bench for the angle-wrapping PID core. A queue-fed driver
// offers sample words and a monitor checks every result against an in-bench
// PID predictor. The run covers directed corner cases, then random register
// settings under several idle and stall mixes and one long output hold-off.
// ----------------------------------------------------------------------------
module pid_controller_angle_wrap_core_tb;

    localparam int          CYCLE_LIMIT = 400000;
    localparam int          LONG_HOLD   = 300;
    localparam longint      TURN_Q16    = 360 * 65536;
    localparam logic [31:0] Q_MAX       = 32'h7FFF_FFFF;
    localparam logic [31:0] Q_MIN       = 32'h8000_0000;

    // DUT ports, all known from time zero
    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 cfg_write = 1'b0;
    logic [2:0]           cfg_index = '0;
    logic [31:0]          cfg_data  = '0;
    logic                 in_valid  = 1'b0;
    logic                 in_ready;
    pidaw_pkg::in_word_t  in_data   = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    pidaw_pkg::out_word_t out_data;

    // Predictor copy of the registers and state, at their reset values
    longint   k_p           = 0;
    longint   k_i           = 0;
    longint   k_d           = 0;
    longint   lim_lo        = -2147483647 - 1;
    longint   lim_hi        = 2147483647;
    longint   band_lo       = 0;
    longint   band_hi       = 0;
    logic [2:0] opt_bits    = 3'b001;
    longint   pid_integral  = 0;
    longint   pid_last_meas = 0;

    // Traffic bookkeeping
    pidaw_pkg::in_word_t  sample_queue[$];
    pidaw_pkg::out_word_t predicted_outputs[$];
    int        samples_queued  = 0;
    int        clears_queued   = 0;
    int        outputs_seen    = 0;
    int        bad_words       = 0;
    int        settings_used   = 0;
    int        cycle_count     = 0;
    int        send_idle_pct   = 0;
    int        recv_stall_pct  = 0;
    logic      in_taken        = 1'b0;
    logic      hold_off        = 1'b0;
    logic      pressure_on     = 1'b0;
    longint    walk_meas       = 0;

    pid_controller_angle_wrap_core dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // PID predictor
    // ------------------------------------------------------------------------
    function automatic longint mag(input longint v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic longint clip32(input longint v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    // Q16.16 product, floor rounding
    function automatic longint qmul_floor(input longint a, input longint b);
        return (a * b) >>> 16;
    endfunction

    // Upper limit checked first; with crossed limits, values above it take lim_hi, all others lim_lo
    function automatic longint limit_drive(input longint v);
        if (v > lim_hi)
            return lim_hi;
        if (v < lim_lo)
            return lim_lo;
        return v;
    endfunction

    // Error moves one turn toward zero; ties resolve upward
    function automatic longint wrap_error(input longint e);
        if (mag(e) > mag(e - TURN_Q16))
            return e - TURN_Q16;
        if (mag(e) < mag(e + TURN_Q16))
            return e;
        return e + TURN_Q16;
    endfunction

    // Change uses the mirrored rule; ties resolve downward
    function automatic longint wrap_change(input longint d);
        if (mag(d) > mag(d + TURN_Q16))
            return d + TURN_Q16;
        if (mag(d) < mag(d - TURN_Q16))
            return d;
        return d - TURN_Q16;
    endfunction

    function automatic pidaw_pkg::out_word_t pid_predict(input pidaw_pkg::in_word_t w);
        pidaw_pkg::out_word_t r;
        longint    err;
        longint    chg;
        longint    acc;
        longint    iterm;
        longint    dterm;
        longint    drv;
        longint    center;
        center = longint'(pidaw_pkg::DEADBAND_CENTER) * 65536;
        r = '0;
        if (w.operation == pidaw_pkg::OP_CLEAR)
        begin
            pid_integral  = 0;
            pid_last_meas = 0;
            return r;
        end
        err = longint'(w.target) - longint'(w.measurement);
        chg = longint'(w.measurement) - pid_last_meas;
        if (opt_bits[pidaw_pkg::OPT_ANGLE])
        begin
            err = wrap_error(err);
            chg = wrap_change(chg);
        end
        err = clip32(err);
        chg = clip32(chg);

        // integral update; reported term is taken before the P subtraction
        acc   = clip32(pid_integral + qmul_floor(k_i, err));
        iterm = acc;
        if (!opt_bits[pidaw_pkg::OPT_P_ON_ERROR])
            acc = clip32(acc - qmul_floor(k_p, chg));
        if (opt_bits[pidaw_pkg::OPT_CLAMP])
            acc = limit_drive(acc);

        // drive
        dterm = qmul_floor(k_d, chg);
        drv   = acc - dterm;
        if (opt_bits[pidaw_pkg::OPT_P_ON_ERROR])
            drv = drv + qmul_floor(k_p, err);
        drv = clip32(drv);
        if (opt_bits[pidaw_pkg::OPT_CLAMP])
            drv = limit_drive(drv);

        // deadband pushes inner values out to its edges
        if (band_lo < center && center < band_hi)
        begin
            if (drv > center && drv < band_hi)
                drv = band_hi;
            if (drv < center && drv > band_lo)
                drv = band_lo;
        end

        pid_integral  = acc;
        pid_last_meas = longint'(w.measurement);
        r.drive           = 32'(drv);
        r.integral_term   = 32'(iterm);
        r.derivative_term = 32'(clip32(dterm));
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Driver: new word at the falling edge once the last one was taken
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        in_taken <= in_valid && in_ready;
    end

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!in_valid || in_taken)
            begin
                if (sample_queue.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    in_data  <= sample_queue.pop_front();
                    in_valid <= 1'b1;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
            out_ready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Long receiver hold-off so the pipeline backs up into in_ready
    initial
    begin
        wait (pressure_on);
        @(posedge clk);
        hold_off = 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        hold_off = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Monitor: predict on input handshake, check on output handshake
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin : check_results
        pidaw_pkg::out_word_t want;
        if (rst_n)
        begin
            if (in_valid && in_ready)
                predicted_outputs.push_back(pid_predict(in_data));
            if (out_valid && out_ready)
            begin
                outputs_seen++;
                if (predicted_outputs.size() == 0)
                begin
                    bad_words++;
                    if (bad_words <= 10)
                        $display("unexpected result word %0d: drive %h integral %h deriv %h",
                                 outputs_seen, out_data.drive, out_data.integral_term,
                                 out_data.derivative_term);
                end
                else
                begin
                    want = predicted_outputs.pop_front();
                    if (out_data.drive !== want.drive
                        || out_data.integral_term !== want.integral_term
                        || out_data.derivative_term !== want.derivative_term)
                    begin
                        bad_words++;
                        if (bad_words <= 10)
                            $display({"mismatch on word %0d: drive %h/%h integral %h/%h ",
                                      "deriv %h/%h (exp/got)"},
                                     outputs_seen, want.drive, out_data.drive,
                                     want.integral_term, out_data.integral_term,
                                     want.derivative_term, out_data.derivative_term);
                    end
                end
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d of %0d results seen",
                     cycle_count, outputs_seen, samples_queued);
            $display("[pid_controller_angle_wrap_core] ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    function automatic logic [31:0] q16(input int whole);
        return 32'(longint'(whole) * 65536);
    endfunction

    task automatic queue_word(input logic op, input logic [31:0] meas, input logic [31:0] tgt);
        pidaw_pkg::in_word_t w;
        w.operation   = op;
        w.measurement = meas;
        w.target      = tgt;
        sample_queue.push_back(w);
        samples_queued++;
        if (op == pidaw_pkg::OP_CLEAR)
            clears_queued++;
    endtask

    // One register write per falling edge; predictor copy follows along
    task automatic write_reg(input pidaw_pkg::reg_index_t idx, input logic [31:0] val);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        case (idx)
            pidaw_pkg::REG_GAIN_P:    k_p     = longint'($signed(val));
            pidaw_pkg::REG_GAIN_I:    k_i     = longint'($signed(val));
            pidaw_pkg::REG_GAIN_D:    k_d     = longint'($signed(val));
            pidaw_pkg::REG_DRIVE_MIN: lim_lo  = longint'($signed(val));
            pidaw_pkg::REG_DRIVE_MAX: lim_hi  = longint'($signed(val));
            pidaw_pkg::REG_BAND_LOW:  band_lo = longint'($signed(val));
            pidaw_pkg::REG_BAND_HIGH: band_hi = longint'($signed(val));
            pidaw_pkg::REG_OPTIONS:   opt_bits = val[2:0];
            default:       ;
        endcase
        @(negedge clk);
    endtask

    task automatic program_all(input logic [31:0] gp, input logic [31:0] gi,
                               input logic [31:0] gd, input logic [31:0] lo,
                               input logic [31:0] hi, input logic [31:0] bl,
                               input logic [31:0] bh, input logic [2:0] opt);
        write_reg(pidaw_pkg::REG_GAIN_P, gp);
        write_reg(pidaw_pkg::REG_GAIN_I, gi);
        write_reg(pidaw_pkg::REG_GAIN_D, gd);
        write_reg(pidaw_pkg::REG_DRIVE_MIN, lo);
        write_reg(pidaw_pkg::REG_DRIVE_MAX, hi);
        write_reg(pidaw_pkg::REG_BAND_LOW, bl);
        write_reg(pidaw_pkg::REG_BAND_HIGH, bh);
        write_reg(pidaw_pkg::REG_OPTIONS, {29'd0, opt});
        cfg_write <= 1'b0;
        @(negedge clk);
        settings_used++;
    endtask

    function automatic logic [31:0] pick_gain();
        int sel;
        sel = $urandom_range(9);
        if (sel == 0)
            return Q_MIN;
        if (sel == 1)
            return Q_MAX;
        if (sel < 4)
            return $urandom();
        // mostly modest gains within +/-4.0
        return 32'(int'($urandom_range(0, 8 * 65536)) - 4 * 65536);
    endfunction

    task automatic program_random();
        logic [31:0] lo;
        logic [31:0] hi;
        logic [31:0] bl;
        logic [31:0] bh;
        int          sel;
        sel = $urandom_range(3);
        if (sel == 0)
        begin
            lo = Q_MIN;
            hi = Q_MAX;
        end
        else if (sel == 1)
        begin
            // crossed limits
            lo = q16($urandom_range(1, 500));
            hi = q16(-int'($urandom_range(1, 500)));
        end
        else if (sel == 2)
        begin
            lo = q16(-int'($urandom_range(0, 500)));
            hi = q16($urandom_range(0, 500));
        end
        else
        begin
            lo = $urandom();
            hi = $urandom();
        end
        sel = $urandom_range(2);
        if (sel == 0)
        begin
            bl = '0;
            bh = '0;
        end
        else if (sel == 1)
        begin
            bl = q16(-int'($urandom_range(1, 20)));
            bh = q16($urandom_range(1, 20));
        end
        else
        begin
            bl = $urandom();
            bh = $urandom();
        end
        program_all(pick_gain(), pick_gain(), pick_gain(), lo, hi, bl, bh,
                    3'($urandom_range(7)));
    endtask

    // Mostly a wandering measurement with a nearby setpoint, plus noise and clears
    task automatic queue_random(input int count);
        int     pick;
        longint offset;
        for (int n = 0; n < count; n++)
        begin
            pick = $urandom_range(99);
            if (pick < 4)
            begin
                queue_word(pidaw_pkg::OP_CLEAR, $urandom(), $urandom());
            end
            else if (pick < 20)
            begin
                queue_word(pidaw_pkg::OP_COMPUTE, $urandom(), $urandom());
            end
            else
            begin
                walk_meas = walk_meas + int'($urandom_range(0, 80 * 65536)) - 40 * 65536;
                if (walk_meas > 720 * 65536 || walk_meas < -720 * 65536)
                    walk_meas = 0;
                offset = int'($urandom_range(0, 400 * 65536)) - 200 * 65536;
                queue_word(pidaw_pkg::OP_COMPUTE, 32'(walk_meas), 32'(walk_meas + offset));
            end
        end
    endtask

    task automatic wait_results();
        while (outputs_seen < samples_queued)
            @(negedge clk);
    endtask

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial
    begin
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // P on error, no clamps: field extremes and saturated error
        program_all(q16(1), 32'h0000_8000, 32'h0000_4000, Q_MIN, Q_MAX, '0, '0, 3'b001);
        queue_word(pidaw_pkg::OP_COMPUTE, '0, '0);
        queue_word(pidaw_pkg::OP_COMPUTE, Q_MAX, Q_MIN);
        queue_word(pidaw_pkg::OP_COMPUTE, Q_MIN, Q_MAX);
        queue_word(pidaw_pkg::OP_CLEAR, Q_MAX, Q_MAX);
        queue_word(pidaw_pkg::OP_COMPUTE, 32'h7FFF_0000, '0);
        queue_word(pidaw_pkg::OP_COMPUTE, 32'hFFFF_FFFF, 32'h0000_0001);
        wait_results();

        // P on measurement with extreme gains
        program_all(Q_MAX, Q_MIN, Q_MAX, Q_MIN, Q_MAX, '0, '0, 3'b000);
        queue_word(pidaw_pkg::OP_COMPUTE, q16(100), q16(-100));
        queue_word(pidaw_pkg::OP_COMPUTE, Q_MIN, Q_MAX);
        queue_word(pidaw_pkg::OP_COMPUTE, Q_MAX, Q_MIN);
        queue_word(pidaw_pkg::OP_CLEAR, '0, '0);
        wait_results();

        // angle mode: wrap, half-turn ties both ways, and a value several turns out
        program_all(q16(1), q16(1), q16(1), Q_MIN, Q_MAX, '0, '0, 3'b011);
        queue_word(pidaw_pkg::OP_CLEAR, '0, '0);
        queue_word(pidaw_pkg::OP_COMPUTE, q16(350), q16(10));
        queue_word(pidaw_pkg::OP_COMPUTE, q16(170), q16(-10));
        queue_word(pidaw_pkg::OP_COMPUTE, q16(-10), q16(170));
        queue_word(pidaw_pkg::OP_COMPUTE, q16(170), q16(350));
        queue_word(pidaw_pkg::OP_COMPUTE, q16(1000), q16(-1000));
        wait_results();

        // clamps with drive_min above drive_max
        program_all(q16(2), q16(1), '0, q16(50), q16(-50), '0, '0, 3'b101);
        queue_word(pidaw_pkg::OP_CLEAR, '0, '0);
        queue_word(pidaw_pkg::OP_COMPUTE, '0, q16(100));
        queue_word(pidaw_pkg::OP_COMPUTE, '0, q16(-100));
        wait_results();

        // deadband around zero, including a drive exactly on its edge
        program_all(32'h0000_4000, '0, '0, q16(-1000), q16(1000), q16(-5), q16(5), 3'b101);
        queue_word(pidaw_pkg::OP_CLEAR, '0, '0);
        queue_word(pidaw_pkg::OP_COMPUTE, '0, q16(1));
        queue_word(pidaw_pkg::OP_COMPUTE, '0, q16(-1));
        queue_word(pidaw_pkg::OP_COMPUTE, '0, '0);
        queue_word(pidaw_pkg::OP_COMPUTE, '0, q16(20));
        wait_results();

        // random phases under rotating idle mixes
        for (int ph = 0; ph < 8; ph++)
        begin
            send_idle_pct  = (ph % 4 == 1) ? 64 : (ph % 4 == 3) ? 38 : 0;
            recv_stall_pct = (ph % 4 == 2) ? 64 : (ph % 4 == 3) ? 38 : 0;
            if (ph == 0)
                program_all(Q_MIN, Q_MAX, Q_MIN, Q_MAX, Q_MIN, Q_MIN, Q_MAX, 3'b111);
            else
                program_random();
            queue_random(130);
            wait_results();
        end

        // back-pressure: sender runs free while the receiver holds off
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        program_random();
        queue_random(60);
        pressure_on = 1'b1;
        wait_results();

        repeat (16) @(negedge clk);
        if (predicted_outputs.size() != 0)
            $display("%0d predicted results never arrived", predicted_outputs.size());
        $display("Ran %0d sample words (%0d clears) across %0d register settings;",
                 samples_queued, clears_queued, settings_used);
        $display("%0d results checked, %0d bad. Traffic mixed free flow, sender gaps,",
                 outputs_seen, bad_words);
        $display("receiver stalls, both, and a %0d-cycle output hold-off.", LONG_HOLD);
        if (bad_words == 0 && predicted_outputs.size() == 0)
            $display("[pid_controller_angle_wrap_core] OK");
        else
            $display("[pid_controller_angle_wrap_core] ERROR");
        $finish;
    end

endmodule
